[rtl/arst_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// arst_pkg
// Shared constants and types for the ack retransmit slot table.
// ----------------------------------------------------------------------------
package arst_pkg;

  localparam int NUM_SLOTS_DEF = 8;

  typedef enum logic [2:0] {
    KIND_SEND   = 3'd0,
    KIND_ACK    = 3'd1,
    KIND_CANCEL = 3'd2,
    KIND_QUERY  = 3'd3,
    KIND_TICK   = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    EV_TX     = 3'd0,
    EV_REJECT = 3'd1,
    EV_DONE   = 3'd2,
    EV_RETX   = 3'd3,
    EV_QUERY  = 3'd4
  } event_t;

  localparam logic [1:0] REG_MIN_LEN   = 2'd0;
  localparam logic [1:0] REG_MAX_LEN   = 2'd1;
  localparam logic [1:0] REG_TIMEOUT   = 2'd2;
  localparam logic [1:0] REG_RETRY_LIM = 2'd3;

  // one slot entry as stored in the slot memory
  typedef struct packed {
    logic [47:0] peer;
    logic [15:0] seq;
    logic [7:0]  mtype;
    logic [31:0] cookie;
    logic [4:0]  tries;
    logic [31:0] sent_at;
    logic [7:0]  len;
  } slot_t;

endpackage : arst_pkg
`default_nettype wire

[rtl/ack_retransmit_slot_table.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ack_retransmit_slot_table
// ARQ slot tracker: send, ack, cancel, pending query and tick over a slot table.
// ----------------------------------------------------------------------------
// One item at a time: busy is high from the cycle after start until the cycle
// after the last result word is out. Send and rejected sends give a single
// result word. Ack, cancel, query and tick walk the slot memory one slot per
// cycle through its single read port. A tick or cancel ends with a drain
// step when a held word and a new word are both due on the final slot.
// Result words appear with strobe for one cycle each and cannot be held off;
// last marks the item's final word. Used flags live in flip-flops, so reset
// needs no clearing pass.
module ack_retransmit_slot_table #(
  parameter int NUM_SLOTS = arst_pkg::NUM_SLOTS_DEF,
  localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  output logic        busy,
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [15:0] cfg_data,
  input  wire  [2:0]  kind,
  input  wire  [47:0] peer_addr,
  input  wire  [15:0] msg_seq,
  input  wire  [7:0]  msg_type,
  input  wire  [31:0] cookie,
  input  wire  [7:0]  frame_len,
  input  wire  [7:0]  ack_status,
  output logic        strobe,
  output logic [2:0]  event_res,
  output logic [2:0]  slot_index,
  output logic [47:0] peer_out,
  output logic [15:0] seq_out,
  output logic [7:0]  type_out,
  output logic [31:0] cookie_out,
  output logic [7:0]  len_out,
  output logic        delivered,
  output logic [7:0]  status_out,
  output logic        pending,
  output logic        last
);
  import arst_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SEND} state_t;

  logic [7:0]  min_len, max_len;
  logic [15:0] ack_timeout;
  logic [3:0]  retry_limit;
  logic [31:0] time_now;

  state_t      state;
  logic [NUM_SLOTS-1:0] used;
  logic [2:0]  op;
  logic [47:0] r_peer;
  logic [15:0] r_seq;
  logic [7:0]  r_type, r_status;
  logic [AW:0] rd_cnt;     // next slot to read
  logic        chk_vld;    // read data valid this cycle
  logic [AW-1:0] chk_idx;
  logic        found;      // ack/query already hit
  logic [AW-1:0] free_idx;
  logic        free_ok;

  logic        we;
  logic [AW-1:0] waddr, raddr;
  slot_t       wdata, rdata;

  arst_slot_mem #(.NUM_SLOTS(NUM_SLOTS)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign raddr = rd_cnt[AW-1:0];

  always_comb begin
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_ok  = 1'b1;
        free_idx = AW'(i);
      end
    end
  end

  // per-slot decisions on the word just read
  logic        u_c, peer_eq, hit_ack, hit_can, hit_qry, due, expire, retx;
  logic        scan_end;
  always_comb begin
    u_c      = chk_vld && used[chk_idx];
    peer_eq  = rdata.peer == r_peer;
    hit_ack  = u_c && !found && peer_eq && rdata.seq == r_seq;
    hit_can  = u_c && peer_eq;
    hit_qry  = u_c && !found && peer_eq && rdata.mtype == r_type;
    due      = u_c && ((time_now - rdata.sent_at) >= {16'd0, ack_timeout});
    expire   = due && (rdata.tries > {1'b0, retry_limit});
    retx     = due && !expire;
    scan_end = chk_vld && (chk_idx == AW'(NUM_SLOTS - 1));
  end

  // remaining used slots after chk_idx that will produce a tick/cancel word
  // is unknown ahead, so a trailing word is flagged via a lookahead-free
  // scheme: results are held until replaced and last is set when scan finishes.
  logic        hold_vld;
  logic [2:0]  h_ev;
  logic [AW-1:0] h_idx;
  slot_t       h_slot;
  logic        h_dlv;
  logic [7:0]  h_st;

  logic        emit;
  logic [2:0]  e_ev;
  logic        e_dlv;
  logic [7:0]  e_st;
  always_comb begin
    emit = 1'b0; e_ev = EV_DONE; e_dlv = 1'b0; e_st = 8'd0;
    we = 1'b0; waddr = chk_idx; wdata = rdata;
    unique case (op)
      KIND_ACK: if (hit_ack) begin
        emit = 1'b1; e_dlv = 1'b1; e_st = r_status;
      end
      KIND_CANCEL: emit = hit_can;
      KIND_TICK: begin
        if (expire) emit = 1'b1;
        if (retx) begin
          emit = 1'b1; e_ev = EV_RETX; we = 1'b1;
          wdata.tries = rdata.tries + 5'd1;
          wdata.sent_at = time_now;
        end
      end
      default: ;
    endcase
    if (state == S_IDLE && start && kind == KIND_SEND && free_ok &&
        frame_len >= min_len && frame_len <= max_len) begin
      we = 1'b1; waddr = free_idx;
      wdata = '{peer: peer_addr, seq: msg_seq, mtype: msg_type, cookie: cookie,
                tries: 5'd1, sent_at: time_now, len: frame_len};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; busy <= 1'b0; used <= '0; time_now <= '0;
      min_len <= 8'd8; max_len <= 8'd250; ack_timeout <= 16'd200;
      retry_limit <= 4'd3; chk_vld <= 1'b0; hold_vld <= 1'b0;
      strobe <= 1'b0; last <= 1'b0; found <= 1'b0; rd_cnt <= '0; op <= '0;
    end else begin
      strobe <= 1'b0; last <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MIN_LEN:   min_len <= cfg_data[7:0];
          REG_MAX_LEN:   max_len <= cfg_data[7:0];
          REG_TIMEOUT:   ack_timeout <= cfg_data;
          REG_RETRY_LIM: retry_limit <= cfg_data[3:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: if (start) begin
          op <= kind; r_peer <= peer_addr; r_seq <= msg_seq; r_type <= msg_type;
          r_status <= ack_status;
          found <= 1'b0; rd_cnt <= '0; chk_vld <= 1'b0;
          if (kind == KIND_SEND) begin
            busy <= 1'b1; state <= S_SEND;
            if (free_ok && frame_len >= min_len && frame_len <= max_len) begin
              used[free_idx] <= 1'b1;
              event_res <= EV_TX; slot_index <= 3'(free_idx);
            end else begin
              event_res <= EV_REJECT; slot_index <= 3'd0;
            end
            peer_out <= peer_addr; seq_out <= msg_seq; type_out <= msg_type;
            cookie_out <= cookie; len_out <= frame_len; delivered <= 1'b0;
            status_out <= 8'd0; pending <= 1'b0;
            strobe <= 1'b1; last <= 1'b1;
          end else if (kind == KIND_ACK || kind == KIND_CANCEL ||
                       kind == KIND_QUERY || kind == KIND_TICK) begin
            busy <= 1'b1; state <= S_SCAN;
            if (kind == KIND_TICK) time_now <= time_now + 32'd1;
          end
        end
        S_SEND: begin
          busy <= 1'b0; state <= S_IDLE;
        end
        S_SCAN: begin
          if (rd_cnt != (AW+1)'(NUM_SLOTS)) rd_cnt <= rd_cnt + (AW+1)'(1);
          chk_vld <= rd_cnt != (AW+1)'(NUM_SLOTS);
          chk_idx <= rd_cnt[AW-1:0];
          if ((op == KIND_ACK && hit_ack) || (op == KIND_QUERY && hit_qry))
            found <= 1'b1;
          if (op == KIND_QUERY && hit_qry) h_idx <= chk_idx;
          if ((op == KIND_ACK && hit_ack) || (op == KIND_CANCEL && hit_can) ||
              (op == KIND_TICK && expire)) used[chk_idx] <= 1'b0;
          // flush the held word when a new one replaces it
          if (emit) begin
            if (hold_vld) begin
              strobe <= 1'b1; last <= 1'b0;
              event_res <= h_ev; slot_index <= 3'(h_idx);
              peer_out <= h_slot.peer; seq_out <= h_slot.seq;
              type_out <= h_slot.mtype; cookie_out <= h_slot.cookie;
              len_out <= h_slot.len; delivered <= h_dlv; status_out <= h_st;
              pending <= 1'b0;
            end
            hold_vld <= 1'b1; h_ev <= e_ev; h_idx <= chk_idx; h_slot <= rdata;
            h_dlv <= e_dlv; h_st <= e_st;
          end
          if (scan_end) begin
            state <= S_SEND; chk_vld <= 1'b0; hold_vld <= 1'b0;
            if (op == KIND_QUERY) begin
              strobe <= 1'b1; last <= 1'b1; event_res <= EV_QUERY;
              slot_index <= (found || hit_qry) ? 3'(hit_qry ? chk_idx : h_idx)
                                              : 3'd0;
              peer_out <= r_peer; seq_out <= 16'd0; type_out <= r_type;
              cookie_out <= 32'd0; len_out <= 8'd0; delivered <= 1'b0;
              status_out <= 8'd0; pending <= found || hit_qry;
            end else if (emit || hold_vld) begin
              strobe <= 1'b1; last <= 1'b1;
              if (emit && hold_vld) begin
                // two words due at once: emit held now, new one next cycle
                last <= 1'b0;
                hold_vld <= 1'b1; state <= S_SCAN; rd_cnt <= (AW+1)'(NUM_SLOTS);
              end else if (emit) begin
                event_res <= e_ev; slot_index <= 3'(chk_idx);
                peer_out <= rdata.peer; seq_out <= rdata.seq;
                type_out <= rdata.mtype; cookie_out <= rdata.cookie;
                len_out <= rdata.len; delivered <= e_dlv; status_out <= e_st;
                pending <= 1'b0;
              end else begin
                event_res <= h_ev; slot_index <= 3'(h_idx);
                peer_out <= h_slot.peer; seq_out <= h_slot.seq;
                type_out <= h_slot.mtype; cookie_out <= h_slot.cookie;
                len_out <= h_slot.len; delivered <= h_dlv; status_out <= h_st;
                pending <= 1'b0;
              end
            end
          end else if (!chk_vld && rd_cnt == (AW+1)'(NUM_SLOTS) && hold_vld &&
                       op != KIND_QUERY) begin
            // drain of the final held word after a double hit on the last slot
            strobe <= 1'b1; last <= 1'b1; hold_vld <= 1'b0; state <= S_SEND;
            event_res <= h_ev; slot_index <= 3'(h_idx);
            peer_out <= h_slot.peer; seq_out <= h_slot.seq;
            type_out <= h_slot.mtype; cookie_out <= h_slot.cookie;
            len_out <= h_slot.len; delivered <= h_dlv; status_out <= h_st;
            pending <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule : ack_retransmit_slot_table
`default_nettype wire

[rtl/arst_slot_mem.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// arst_slot_mem
// Slot payload memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module arst_slot_mem #(
  parameter int NUM_SLOTS = arst_pkg::NUM_SLOTS_DEF,
  localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  wire                clk,
  input  wire                we,
  input  wire [AW-1:0]       waddr,
  input  arst_pkg::slot_t    wdata,
  input  wire [AW-1:0]       raddr,
  output arst_pkg::slot_t    rdata
);
  import arst_pkg::*;

  slot_t mem [NUM_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : arst_slot_mem
`default_nettype wire
